### hdl/tssf_pkg.sv
`default_nettype none

package tssf_pkg;

   // Width of one converted X or Y sample.
   localparam int SAMPLE_BITS = 12;

   // Jitter limit register.
   localparam int LIMIT_BITS = 12;
   localparam logic [LIMIT_BITS-1:0] ERROR_LIMIT_RESET = LIMIT_BITS'(10);

   // Deviation compares run at the wider of sample and limit widths.
   localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

   // Event kinds carried on the request tuser.
   localparam int OP_BITS = 2;
   localparam logic [OP_BITS-1:0] OP_PEN_IRQ   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_CONV_DONE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TIMER     = 2'd2;
   localparam logic [OP_BITS-1:0] OP_UNUSED    = 2'd3;

   // Touch modes.
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_WAIT_DOWN = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WAIT_UP   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_MEASURE   = 2'd2;

   // Samples per filtered batch.
   localparam int BATCH_SIZE = 4;
   localparam int COUNT_BITS = $clog2(BATCH_SIZE);
   localparam logic [COUNT_BITS-1:0] LAST_INDEX = COUNT_BITS'(BATCH_SIZE - 1);

   // Request beat payload, lowest field in the lowest bits.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] y_sample;
      logic [SAMPLE_BITS-1:0] x_sample;
      logic                   pen_up;
   } req_data_type;

   // Response beat payload, lowest field in the lowest bits.
   typedef struct packed {
      logic                   resample_armed;
      logic [SAMPLE_BITS-1:0] mean_y;
      logic [SAMPLE_BITS-1:0] mean_x;
      logic                   filter_pass;
      logic                   report_valid;
      logic                   start_conversion;
      logic [MODE_BITS-1:0]   touch_mode;
   } rsp_data_type;

   localparam int REQ_FIELD_BITS = $bits(req_data_type);
   localparam int RSP_FIELD_BITS = $bits(rsp_data_type);
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

### hdl/touch_sample_sequencer_filter.sv
// Touch controller sequencer with a four-sample jitter filter.
//
// Request channel (req_*): one beat per event. req_tuser carries the event
// kind (pen interrupt, conversion done, timer tick); req_tdata carries the
// pen-up bit and one X/Y sample pair. The unused event kind is ignored and
// only echoes the current mode.
// Response channel (rsp_*): exactly one beat per request beat, in order,
// with the new mode, the conversion request and, on the fourth stored
// sample pair, the filter verdict and the truncated four-sample mean.
// CSR channel (csr_*): writes the 12-bit jitter limit; always ready. Write
// it only while no event is in flight.
//
// A request beat travels to the response beat through one input
// register, then the sequencer and filter logic into the response register.
// Throughput is one event per cycle while rsp_tready stays high; the sequencer
// state updates as the input register hands its event to the response register.
// When the receiver stalls, the response register holds its beat, the
// input register fills, and req_tready drops until rsp_tready returns.
// Reset empties both registers, selects wait pen down, clears the sample
// count and loads the limit with 10. Stored samples are not cleared.
`default_nettype none

module touch_sample_sequencer_filter
   import tssf_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   // Event beats.
   input  wire                         req_tvalid,
   output logic                        req_tready,
   // tdata, from bit 0: pen_up, x_sample, y_sample, zero fill.
   input  wire  [REQ_TDATA_BITS-1:0]   req_tdata,
   // tuser: event_opcode.
   input  wire  [OP_BITS-1:0]          req_tuser,
   // Result beats.
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   // tdata, from bit 0: touch_mode, start_conversion, report_valid,
   // filter_pass, mean_x, mean_y, resample_armed, zero fill.
   output logic [RSP_TDATA_BITS-1:0]   rsp_tdata,
   // Jitter limit writes.
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [LIMIT_BITS-1:0]       csr_data
);

   // Input register.
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [OP_BITS-1:0]     in_op_ff;
   req_data_type           in_data_ff;

   // Response register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_data_type           rsp_data_ff;
   rsp_data_type           rsp_data_in;

   // Sequencer state.
   logic [MODE_BITS-1:0]   mode_ff;
   logic [MODE_BITS-1:0]   mode_in;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic [LIMIT_BITS-1:0]  limit_ff;
   logic [SAMPLE_BITS-1:0] x_store_ff [BATCH_SIZE];
   logic [SAMPLE_BITS-1:0] y_store_ff [BATCH_SIZE];

   logic                   advance;
   logic                   store_en;
   logic                   batch_done;
   logic                   pass_x;
   logic                   pass_y;
   logic [SAMPLE_BITS+1:0] sum_x;
   logic [SAMPLE_BITS+1:0] sum_y;

   // Checks the two neighbor-mean deviations of one axis; s3 is the new sample.
   function automatic logic jitter_ok(
      input logic [SAMPLE_BITS-1:0] s0,
      input logic [SAMPLE_BITS-1:0] s1,
      input logic [SAMPLE_BITS-1:0] s2,
      input logic [SAMPLE_BITS-1:0] s3,
      input logic [LIMIT_BITS-1:0]  lim
   );
      logic [SAMPLE_BITS:0]   pair01;
      logic [SAMPLE_BITS:0]   pair12;
      logic [SAMPLE_BITS-1:0] avg01;
      logic [SAMPLE_BITS-1:0] avg12;
      logic [SAMPLE_BITS-1:0] dev2;
      logic [SAMPLE_BITS-1:0] dev3;
      pair01 = {1'b0, s0} + {1'b0, s1};
      pair12 = {1'b0, s1} + {1'b0, s2};
      avg01  = pair01[SAMPLE_BITS:1];
      avg12  = pair12[SAMPLE_BITS:1];
      dev2   = (s2 > avg01) ? (s2 - avg01) : (avg01 - s2);
      dev3   = (s3 > avg12) ? (s3 - avg12) : (avg12 - s3);
      return (CMP_BITS'(dev2) <= CMP_BITS'(lim)) && (CMP_BITS'(dev3) <= CMP_BITS'(lim));
   endfunction

   // Handshake: the input register moves on whenever the response slot frees.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(rsp_data_ff);

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // Batch arithmetic, using the incoming pair as the fourth sample.
   assign sum_x = (SAMPLE_BITS+2)'(x_store_ff[0]) + (SAMPLE_BITS+2)'(x_store_ff[1])
                + (SAMPLE_BITS+2)'(x_store_ff[2]) + (SAMPLE_BITS+2)'(in_data_ff.x_sample);
   assign sum_y = (SAMPLE_BITS+2)'(y_store_ff[0]) + (SAMPLE_BITS+2)'(y_store_ff[1])
                + (SAMPLE_BITS+2)'(y_store_ff[2]) + (SAMPLE_BITS+2)'(in_data_ff.y_sample);
   assign pass_x = jitter_ok(x_store_ff[0], x_store_ff[1], x_store_ff[2],
                             in_data_ff.x_sample, limit_ff);
   assign pass_y = jitter_ok(y_store_ff[0], y_store_ff[1], y_store_ff[2],
                             in_data_ff.y_sample, limit_ff);

   // Sequencer decision for the event in the input register.
   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      store_en    = 1'b0;
      batch_done  = 1'b0;
      rsp_data_in = '0;
      if (in_op_ff == OP_UNUSED) begin
         mode_in = mode_ff;
      end else if (in_data_ff.pen_up) begin
         mode_in  = MODE_WAIT_DOWN;
         count_in = '0;
      end else if (in_op_ff != OP_CONV_DONE) begin
         mode_in                      = MODE_MEASURE;
         rsp_data_in.start_conversion = 1'b1;
      end else begin
         store_en = 1'b1;
         if (count_ff == LAST_INDEX) begin
            batch_done                 = 1'b1;
            count_in                   = '0;
            mode_in                    = MODE_WAIT_UP;
            rsp_data_in.report_valid   = 1'b1;
            rsp_data_in.filter_pass    = pass_x && pass_y;
            rsp_data_in.mean_x         = sum_x[SAMPLE_BITS+1:2];
            rsp_data_in.mean_y         = sum_y[SAMPLE_BITS+1:2];
            rsp_data_in.resample_armed = 1'b1;
         end else begin
            count_in                     = count_ff + COUNT_BITS'(1);
            mode_in                      = MODE_MEASURE;
            rsp_data_in.start_conversion = 1'b1;
         end
      end
      rsp_data_in.touch_mode = mode_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_WAIT_DOWN;
         count_ff     <= '0;
         limit_ff     <= ERROR_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   // Payload registers and sample store.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_data_type'(req_tdata[REQ_FIELD_BITS-1:0]);
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (advance && store_en) begin
         x_store_ff[count_ff] <= in_data_ff.x_sample;
         y_store_ff[count_ff] <= in_data_ff.y_sample;
      end
   end

   // A new beat never lands on a full input register that is not moving on.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!in_valid_ff || advance))
      else $error("input register overwritten while holding an event");

   // A completed batch always leaves the block waiting for pen up.
   assert property (@(posedge clock) disable iff (reset)
      (advance && batch_done) |=> (mode_ff == MODE_WAIT_UP && count_ff == '0))
      else $error("batch completion did not reset the sequencer");

   // A report and a conversion request never share one result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.report_valid && rsp_data_ff.start_conversion))
      else $error("report and conversion request in the same result");

   // A conversion request is only issued in measure mode.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.start_conversion)
         |-> (rsp_data_ff.touch_mode == MODE_MEASURE))
      else $error("conversion requested outside measure mode");

endmodule

`default_nettype wire
